### rtl/grc_pkg.sv
// Shared types, constants and register codes for the gamepad report conditioner.
`default_nettype none

package grc_pkg;

    // Largest report size that is examined; bytes at or beyond it are never read.
    localparam int REPORT_BYTES = 16;
    localparam int LEN_W        = $clog2(REPORT_BYTES + 1);

    // Stick processing needs bytes 2 and 3.
    localparam int STICK_MIN_LEN = 4;

    // Stream widths, padded to whole bytes.
    localparam int IN_BITS   = 64 + 64 + 8 + 1;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 + 1 + 17 + 1 + 1;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register reset values.
    localparam logic [15:0] CENTER_Y_RST  = 16'd29351;
    localparam logic [15:0] DEADZONE_RST  = 16'd3932;
    localparam logic [16:0] THRESHOLD_RST = 17'd1638;
    localparam logic [3:0]  BAL_BYTE_RST  = 4'd0;
    localparam logic [7:0]  BAL_MASK_RST  = 8'd1;
    localparam logic [3:0]  TRIM_BYTE_RST = 4'd0;
    localparam logic [7:0]  TRIM_MASK_RST = 8'd2;
    localparam logic [5:0]  MIN_LEN_RST   = 6'd4;

    // Full-scale stick magnitude in Q1.15.
    localparam logic signed [16:0] STICK_FULL = 17'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_Y   = 3'd0,
        CFG_DEADZONE   = 3'd1,
        CFG_THRESHOLD  = 3'd2,
        CFG_BAL_BYTE   = 3'd3,
        CFG_BAL_MASK   = 3'd4,
        CFG_TRIM_BYTE  = 3'd5,
        CFG_TRIM_MASK  = 3'd6,
        CFG_MIN_LENGTH = 3'd7
    } grc_cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } grc_action_t;

    typedef struct packed {
        logic [15:0] center_y;
        logic [15:0] deadzone;
        logic [16:0] change_threshold;
        logic [3:0]  balance_byte;
        logic [7:0]  balance_mask;
        logic [3:0]  trim_byte;
        logic [7:0]  trim_mask;
        logic [5:0]  min_length;
    } grc_cfg_t;

    typedef struct packed {
        logic        balancer_active;
        logic [7:0]  report_length;
        logic [63:0] report_high;
        logic [63:0] report_low;
    } grc_item_t;

    typedef struct packed {
        logic               balance_button_was;
        logic               trim_button_was;
        logic signed [16:0] last_drive;
    } grc_state_t;

    typedef struct packed {
        logic               send_setpoint;
        logic               drive_changed;
        logic signed [16:0] drive_value;
        logic               trim_request;
        grc_action_t        balance_action;
    } grc_result_t;

endpackage

`default_nettype wire

### rtl/grc_core.sv
// Combinational conditioning of one report: button release detection and stick drive value.
`default_nettype none

module grc_core (
    input  grc_pkg::grc_item_t   item,
    input  grc_pkg::grc_cfg_t    cfg,
    input  grc_pkg::grc_state_t  state,
    output grc_pkg::grc_result_t result,
    output grc_pkg::grc_state_t  state_next
);

    logic [7:0]                 rep_bytes [16];
    logic [grc_pkg::LEN_W-1:0]  len_use;
    logic [7:0]                 len_ext;
    logic                       buttons_ok;
    logic                       bal_seen;
    logic                       trim_seen;
    logic                       bal_now;
    logic                       trim_now;
    grc_pkg::grc_action_t       action;
    logic                       active_after;
    logic [15:0]                raw_y;
    logic signed [16:0]         y_centered;
    logic signed [16:0]         y_clamped;
    logic signed [16:0]         y_mag;
    logic signed [16:0]         y_drive;
    logic signed [17:0]         diff;
    logic [17:0]                diff_abs;
    logic                       stick_ok;
    logic                       moved;

    // Split the report into bytes, byte 0 lowest.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            rep_bytes[i]     = item.report_low[i*8 +: 8];
            rep_bytes[i + 8] = item.report_high[i*8 +: 8];
        end
    end

    // Usable length is the report length limited to the largest report size.
    always_comb
    begin
        if (item.report_length > 8'(grc_pkg::REPORT_BYTES))
        begin
            len_use = grc_pkg::LEN_W'(grc_pkg::REPORT_BYTES);
        end
        else
        begin
            len_use = item.report_length[grc_pkg::LEN_W-1:0];
        end
    end

    assign len_ext    = 8'(len_use);
    assign buttons_ok = len_ext >= 8'(cfg.min_length);
    assign bal_seen   = buttons_ok && (len_ext > 8'(cfg.balance_byte));
    assign trim_seen  = buttons_ok && (len_ext > 8'(cfg.trim_byte));
    assign bal_now    = |(rep_bytes[cfg.balance_byte] & cfg.balance_mask);
    assign trim_now   = |(rep_bytes[cfg.trim_byte] & cfg.trim_mask);

    // A release of the balance button toggles the balancer request.
    always_comb
    begin
        action       = grc_pkg::ACT_NONE;
        active_after = item.balancer_active;
        if (bal_seen && state.balance_button_was && !bal_now)
        begin
            if (item.balancer_active)
            begin
                action       = grc_pkg::ACT_STOP;
                active_after = 1'b0;
            end
            else
            begin
                action       = grc_pkg::ACT_START;
                active_after = 1'b1;
            end
        end
    end

    // Center, clamp to full scale, apply the deadzone and invert the stick value.
    assign raw_y      = {rep_bytes[3], rep_bytes[2]};
    assign y_centered = signed'({1'b0, raw_y}) - signed'({1'b0, cfg.center_y});

    always_comb
    begin
        if (y_centered > grc_pkg::STICK_FULL)
        begin
            y_clamped = grc_pkg::STICK_FULL;
        end
        else if (y_centered < -grc_pkg::STICK_FULL)
        begin
            y_clamped = -grc_pkg::STICK_FULL;
        end
        else
        begin
            y_clamped = y_centered;
        end
    end

    assign y_mag   = (y_clamped < 0) ? -y_clamped : y_clamped;
    assign y_drive = (unsigned'(y_mag) < {1'b0, cfg.deadzone}) ? 17'sd0 : -y_clamped;

    // Movement test against the stored drive value.
    assign diff     = 18'(y_drive) - 18'(state.last_drive);
    assign diff_abs = (diff < 0) ? unsigned'(-diff) : unsigned'(diff);
    assign stick_ok = len_ext >= 8'(grc_pkg::STICK_MIN_LEN);
    assign moved    = stick_ok && (diff_abs > {1'b0, cfg.change_threshold});

    // Next state and result.
    always_comb
    begin
        state_next.balance_button_was = bal_seen  ? bal_now  : state.balance_button_was;
        state_next.trim_button_was    = trim_seen ? trim_now : state.trim_button_was;
        state_next.last_drive         = moved ? y_drive : state.last_drive;

        result.balance_action = action;
        result.trim_request   = trim_seen && state.trim_button_was && !trim_now;
        result.drive_value    = state_next.last_drive;
        result.drive_changed  = moved;
        result.send_setpoint  = moved && active_after;
    end

endmodule

`default_nettype wire

### rtl/gamepad_report_conditioner_unit.sv
// Top level of the gamepad report conditioner: stream ports, registers and state.
`default_nettype none

// Takes one gamepad report per request on the s_axis side and returns one result
// per report on the m_axis side, in order. A report is held in an input register,
// conditioned combinationally and placed in a result register when that register is
// free or being emptied. One report is accepted every cycle while the output is not
// stalled; the button states and stored drive value are updated in the same cycle a
// report moves from the input register to the result register. A stalled output
// holds the result and the input register, and s_axis_tready falls only when both
// are full. Configuration writes are always accepted and must be made while no
// report is in flight.
module gamepad_report_conditioner_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output      logic                               s_axis_tready,
    // report_low[63:0], report_high[127:64], report_length[135:128],
    // balancer_active[136], zero fill above
    input  wire logic [grc_pkg::IN_W-1:0]           s_axis_tdata,
    output      logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // balance_action[1:0], trim_request[2], drive_value[19:3], drive_changed[20],
    // send_setpoint[21], zero fill above
    output      logic [grc_pkg::OUT_W-1:0]          m_axis_tdata,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [grc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [grc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    grc_pkg::grc_cfg_t    cfg_reg;
    grc_pkg::grc_cfg_t    cfg_next;
    grc_pkg::grc_state_t  state_reg;
    grc_pkg::grc_state_t  state_next;
    grc_pkg::grc_item_t   item_reg;
    logic                 item_valid_reg;
    logic                 item_valid_next;
    grc_pkg::grc_result_t result;
    grc_pkg::grc_result_t result_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 in_accept;
    logic                 advance;

    // Handshake control.
    assign advance       = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (grc_pkg::grc_cfg_idx_t'(cfg_index))
                grc_pkg::CFG_CENTER_Y:   cfg_next.center_y         = cfg_data[15:0];
                grc_pkg::CFG_DEADZONE:   cfg_next.deadzone         = cfg_data[15:0];
                grc_pkg::CFG_THRESHOLD:  cfg_next.change_threshold = cfg_data[16:0];
                grc_pkg::CFG_BAL_BYTE:   cfg_next.balance_byte     = cfg_data[3:0];
                grc_pkg::CFG_BAL_MASK:   cfg_next.balance_mask     = cfg_data[7:0];
                grc_pkg::CFG_TRIM_BYTE:  cfg_next.trim_byte        = cfg_data[3:0];
                grc_pkg::CFG_TRIM_MASK:  cfg_next.trim_mask        = cfg_data[7:0];
                grc_pkg::CFG_MIN_LENGTH: cfg_next.min_length       = cfg_data[5:0];
                default:                 cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_y         <= grc_pkg::CENTER_Y_RST;
            cfg_reg.deadzone         <= grc_pkg::DEADZONE_RST;
            cfg_reg.change_threshold <= grc_pkg::THRESHOLD_RST;
            cfg_reg.balance_byte     <= grc_pkg::BAL_BYTE_RST;
            cfg_reg.balance_mask     <= grc_pkg::BAL_MASK_RST;
            cfg_reg.trim_byte        <= grc_pkg::TRIM_BYTE_RST;
            cfg_reg.trim_mask        <= grc_pkg::TRIM_MASK_RST;
            cfg_reg.min_length       <= grc_pkg::MIN_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Conditioning logic between the input and result registers.
    grc_core u_core (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .result     (result),
        .state_next (state_next)
    );

    // Valid flags of the two stages.
    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state: stage valid flags, button history and stored drive value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= s_axis_tdata[grc_pkg::IN_BITS-1:0];
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = grc_pkg::OUT_W'(result_reg);

endmodule

`default_nettype wire

### rtl/grc_checker.sv
// Port-level checks for the gamepad report conditioner and their binding.
`default_nettype none

module grc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [grc_pkg::OUT_W-1:0]      m_axis_tdata
);

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // The balance action is never the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("invalid balance action");

    // A setpoint is only sent with a drive change.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[20])
        else $error("setpoint without drive change");

    // Fill bits above the result fields stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[grc_pkg::OUT_W-1:grc_pkg::OUT_BITS] == '0)
        else $error("result fill bits not zero");

    // The input side is ready whenever no result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind gamepad_report_conditioner_unit grc_checker u_grc_checker (.*);

`default_nettype wire
